// File: hdl/cen_pkg.sv
// ----------------------------------------------------------------------------
// cen_pkg
// Types, character codes and helpers for the character escape notation
// parser.
// ----------------------------------------------------------------------------
package cen_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CH_SPACE    = 21'h000020;
  localparam logic [CP_W-1:0] CH_PLUS     = 21'h00002B;
  localparam logic [CP_W-1:0] CH_ZERO     = 21'h000030;
  localparam logic [CP_W-1:0] CH_NINE     = 21'h000039;
  localparam logic [CP_W-1:0] CH_UPPER_A  = 21'h000041;
  localparam logic [CP_W-1:0] CH_UPPER_F  = 21'h000046;
  localparam logic [CP_W-1:0] CH_UPPER_U  = 21'h000055;
  localparam logic [CP_W-1:0] CH_UPPER_Z  = 21'h00005A;
  localparam logic [CP_W-1:0] CH_BSLASH   = 21'h00005C;
  localparam logic [CP_W-1:0] CH_CARET    = 21'h00005E;
  localparam logic [CP_W-1:0] CH_LOWER_A  = 21'h000061;
  localparam logic [CP_W-1:0] CH_LOWER_F  = 21'h000066;
  localparam logic [CP_W-1:0] CH_LOWER_U  = 21'h000075;
  localparam logic [CP_W-1:0] CH_LOWER_X  = 21'h000078;
  localparam logic [CP_W-1:0] CH_LOWER_Z  = 21'h00007A;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_CARET = 2'd1,
    MODE_DEC   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    HELD_NONE    = 3'd0,
    HELD_ZERO    = 3'd1,
    HELD_BSLASH  = 3'd2,
    HELD_UPPER_U = 3'd3,
    HELD_LOWER_U = 3'd4
  } held_e;

  typedef struct packed {
    logic [CP_W-1:0] char_out;
    logic            rejected;
  } res_t;

  // Up to two results produced by one request, in order.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } pair_t;

  function automatic res_t make_res(logic [CP_W-1:0] v, logic bad);
    res_t r;
    if (bad || v == '0 || v > CP_MAX) begin
      r.char_out = '0;
      r.rejected = 1'b1;
    end else begin
      r.char_out = v;
      r.rejected = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [CP_W-1:0] held_char(held_e h);
    logic [CP_W-1:0] v;
    case (h)
      HELD_ZERO:    v = CH_ZERO;
      HELD_BSLASH:  v = CH_BSLASH;
      HELD_UPPER_U: v = CH_UPPER_U;
      HELD_LOWER_U: v = CH_LOWER_U;
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/cen_in_reg.sv
// ----------------------------------------------------------------------------
// cen_in_reg
// Input register: holds one request until the result stage can take it.
// ----------------------------------------------------------------------------
module cen_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [cen_pkg::CP_W-1:0]  code_point_i,
  input  logic                      end_of_line_i,
  input  logic                      take_i,
  output logic                      fire_o,
  output logic [cen_pkg::CP_W-1:0]  code_point_o,
  output logic                      end_of_line_o
);

  logic                     valid_q, valid_d;
  logic [cen_pkg::CP_W-1:0] cp_q;
  logic                     eol_q;
  logic                     accept;

  assign fire_o  = valid_q && take_i;
  assign stall_o = valid_q && !take_i;
  assign accept  = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cp_q  <= code_point_i;
      eol_q <= end_of_line_i;
    end
  end

  assign code_point_o  = cp_q;
  assign end_of_line_o = eol_q;

endmodule

// File: hdl/cen_parser.sv
// ----------------------------------------------------------------------------
// cen_parser
// Parse state and the per-character decision logic. Produces up to two
// results for each request that fires.
// ----------------------------------------------------------------------------
module cen_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [cen_pkg::CP_W-1:0]  code_point_i,
  input  logic                      end_of_line_i,
  output cen_pkg::pair_t            pair_o
);

  localparam int unsigned AccW = cen_pkg::CP_W + 4;

  cen_pkg::mode_e            mode_q, mode_d;
  cen_pkg::held_e            held_q, held_d;
  logic [cen_pkg::CP_W-1:0]  acc_q, acc_d;
  logic                      ovf_q, ovf_d;

  always_comb begin
    logic                     h_zero;
    logic                     h_other;
    logic                     complete;
    cen_pkg::mode_e           em;
    logic [cen_pkg::CP_W-1:0] ea;
    logic                     eo;
    logic                     is_dec;
    logic                     is_hex;
    logic                     is_letter;
    logic [3:0]               digit;
    logic                     fin_emit;
    logic                     do_plain;
    logic                     f_v;
    logic                     s_v;
    logic [cen_pkg::CP_W-1:0] f_val;
    logic                     f_bad;
    logic [cen_pkg::CP_W-1:0] s_val;
    logic [AccW-1:0]          t;

    h_zero  = (held_q == cen_pkg::HELD_ZERO);
    h_other = (held_q == cen_pkg::HELD_BSLASH) || (held_q == cen_pkg::HELD_UPPER_U) ||
              (held_q == cen_pkg::HELD_LOWER_U);
    complete = !end_of_line_i &&
               (((h_zero || held_q == cen_pkg::HELD_BSLASH) &&
                 code_point_i == cen_pkg::CH_LOWER_X) ||
                ((held_q == cen_pkg::HELD_UPPER_U || held_q == cen_pkg::HELD_LOWER_U) &&
                 code_point_i == cen_pkg::CH_PLUS));

    // A held '0' that is not followed by 'x' is the start of a decimal run.
    em = h_zero ? cen_pkg::MODE_DEC : mode_q;
    ea = h_zero ? '0 : acc_q;
    eo = h_zero ? 1'b0 : ovf_q;

    is_dec = (code_point_i >= cen_pkg::CH_ZERO) && (code_point_i <= cen_pkg::CH_NINE);
    is_letter = ((code_point_i >= cen_pkg::CH_LOWER_A) &&
                 (code_point_i <= cen_pkg::CH_LOWER_Z)) ||
                ((code_point_i >= cen_pkg::CH_UPPER_A) &&
                 (code_point_i <= cen_pkg::CH_UPPER_Z));
    is_hex = is_dec ||
             ((code_point_i >= cen_pkg::CH_LOWER_A) && (code_point_i <= cen_pkg::CH_LOWER_F)) ||
             ((code_point_i >= cen_pkg::CH_UPPER_A) && (code_point_i <= cen_pkg::CH_UPPER_F));
    // Letters 'a'-'f' and 'A'-'F' carry 1..6 in their low nibble.
    digit = is_dec ? code_point_i[3:0] : code_point_i[3:0] + 4'd9;

    fin_emit = eo || (ea != '0);

    mode_d   = mode_q;
    held_d   = cen_pkg::HELD_NONE;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    f_v      = 1'b0;
    f_val    = '0;
    f_bad    = 1'b0;
    s_v      = 1'b0;
    s_val    = '0;
    do_plain = 1'b0;
    t        = '0;

    if (end_of_line_i) begin
      if (h_other) begin
        f_v   = 1'b1;
        f_val = cen_pkg::held_char(held_q);
      end
      case (em)
        cen_pkg::MODE_CARET: begin
          f_v   = 1'b1;
          f_val = cen_pkg::CH_CARET;
        end
        cen_pkg::MODE_DEC, cen_pkg::MODE_HEX: begin
          f_v   = fin_emit;
          f_val = ea;
          f_bad = eo;
        end
        default: begin
        end
      endcase
      mode_d = cen_pkg::MODE_PLAIN;
      acc_d  = '0;
      ovf_d  = 1'b0;
    end else if (complete) begin
      mode_d = cen_pkg::MODE_HEX;
      acc_d  = '0;
      ovf_d  = 1'b0;
    end else begin
      if (h_other) begin
        f_v   = 1'b1;
        f_val = cen_pkg::held_char(held_q);
      end
      mode_d = em;
      acc_d  = ea;
      ovf_d  = eo;
      case (em)
        cen_pkg::MODE_CARET: begin
          if (is_letter) begin
            s_v   = 1'b1;
            s_val = {{(cen_pkg::CP_W-5){1'b0}}, code_point_i[4:0]};
          end else begin
            f_v   = 1'b1;
            f_val = cen_pkg::CH_CARET;
            s_v   = 1'b1;
            s_val = code_point_i;
          end
          mode_d = cen_pkg::MODE_PLAIN;
        end
        cen_pkg::MODE_DEC, cen_pkg::MODE_HEX: begin
          if ((em == cen_pkg::MODE_DEC) ? is_dec : is_hex) begin
            if (!eo) begin
              if (em == cen_pkg::MODE_DEC) begin
                t = ({4'b0, ea} << 3) + ({4'b0, ea} << 1);
              end else begin
                t = {4'b0, ea} << 4;
              end
              t = t + {{(AccW-4){1'b0}}, digit};
              if (t > {4'b0, cen_pkg::CP_MAX}) begin
                ovf_d = 1'b1;
                acc_d = cen_pkg::CP_MAX;
              end else begin
                acc_d = t[cen_pkg::CP_W-1:0];
              end
            end
          end else begin
            f_v      = fin_emit;
            f_val    = ea;
            f_bad    = eo;
            mode_d   = cen_pkg::MODE_PLAIN;
            acc_d    = '0;
            ovf_d    = 1'b0;
            do_plain = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      if (do_plain) begin
        if (code_point_i == cen_pkg::CH_CARET) begin
          mode_d = cen_pkg::MODE_CARET;
        end else if (code_point_i == cen_pkg::CH_ZERO) begin
          held_d = cen_pkg::HELD_ZERO;
          mode_d = cen_pkg::MODE_PLAIN;
        end else if (code_point_i == cen_pkg::CH_BSLASH) begin
          held_d = cen_pkg::HELD_BSLASH;
          mode_d = cen_pkg::MODE_PLAIN;
        end else if (code_point_i == cen_pkg::CH_UPPER_U) begin
          held_d = cen_pkg::HELD_UPPER_U;
          mode_d = cen_pkg::MODE_PLAIN;
        end else if (code_point_i == cen_pkg::CH_LOWER_U) begin
          held_d = cen_pkg::HELD_LOWER_U;
          mode_d = cen_pkg::MODE_PLAIN;
        end else if (is_dec) begin
          mode_d = cen_pkg::MODE_DEC;
          acc_d  = {{(cen_pkg::CP_W-4){1'b0}}, code_point_i[3:0]};
          ovf_d  = 1'b0;
        end else begin
          mode_d = cen_pkg::MODE_PLAIN;
          if (code_point_i != cen_pkg::CH_SPACE) begin
            s_v   = 1'b1;
            s_val = code_point_i;
          end
        end
      end
    end

    pair_o.count  = {1'b0, f_v} + {1'b0, s_v};
    pair_o.first  = f_v ? cen_pkg::make_res(f_val, f_bad) : cen_pkg::make_res(s_val, 1'b0);
    pair_o.second = cen_pkg::make_res(s_val, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cen_pkg::MODE_PLAIN;
      held_q <= cen_pkg::HELD_NONE;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_eol_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && end_of_line_i |=>
      mode_q == cen_pkg::MODE_PLAIN && held_q == cen_pkg::HELD_NONE && !ovf_q)
    else $error("parse state not cleared after end of line");

  a_hex_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !end_of_line_i && held_q == cen_pkg::HELD_BSLASH &&
    code_point_i == cen_pkg::CH_LOWER_X |=> mode_q == cen_pkg::MODE_HEX && acc_q == '0)
    else $error("hex prefix did not start a hex run");

  a_held_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != cen_pkg::HELD_NONE |-> mode_q == cen_pkg::MODE_PLAIN)
    else $error("character held outside plain mode");
`endif

endmodule

// File: hdl/cen_out_buf.sv
// ----------------------------------------------------------------------------
// cen_out_buf
// Two-entry result register. Takes the results of one request at a time
// and presents them in order on the output channel.
// ----------------------------------------------------------------------------
module cen_out_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  cen_pkg::pair_t            pair_i,
  output logic                      ready_o,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [cen_pkg::CP_W-1:0]  char_out_o,
  output logic                      rejected_o,
  output logic                      last_o
);

  logic [1:0]     cnt_q, cnt_d;
  cen_pkg::res_t  slot0_q, slot0_d, slot1_q, slot1_d;
  logic           last0_q, last0_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign ready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    last0_d = last0_q;
    if (load_i && pair_i.count != 2'd0) begin
      cnt_d   = pair_i.count;
      slot0_d = pair_i.first;
      slot1_d = pair_i.second;
      last0_d = (pair_i.count == 2'd1);
    end else if (pop) begin
      // The second slot always holds the last result of its request.
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
      last0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
    last0_q <= last0_d;
  end

  assign char_out_o = slot0_q.char_out;
  assign rejected_o = slot0_q.rejected;
  assign last_o     = last0_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && pair_i.count != 2'd0 |-> cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))
    else $error("results loaded over undelivered results");

  a_two_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && pop |=> cnt_q == 2'd1 && last0_q)
    else $error("second result lost or not marked last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");
`endif

endmodule

// File: hdl/char_escape_notation_parser.sv
// ----------------------------------------------------------------------------
// char_escape_notation_parser
// Turns a line of characters with caret, decimal and hex escapes into the
// code points it denotes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one character per request (code_point_i), or
//   the line terminator (end_of_line_i high). The output channel carries the
//   resulting code points; rejected_o flags a value of zero or one above
//   0x10FFFF, and last_of_run_o marks the last result of an input request.
//   Both channels use valid/stall; a request moves on a clock edge with
//   valid high and stall low.
//   A character is held in an input register, then decided by combinational
//   logic and written to a two-entry result register, from which the first
//   result is presented. One character per cycle is sustained while out_stall_i
//   is low; a character that yields two results fills the result register and
//   holds off the next request until its first result is taken, which is the
//   only internal cause of in_stall_o.
//   When out_stall_i is high the results wait in the result register and
//   the input register fills, then in_stall_o rises.
//   Reset clears the parse state (plain mode, nothing held, no run) and
//   empties both registers.
// ----------------------------------------------------------------------------
module char_escape_notation_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cen_pkg::CP_W-1:0]  code_point_i,
  input  logic                      end_of_line_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cen_pkg::CP_W-1:0]  char_out_o,
  output logic                      rejected_o,
  output logic                      last_of_run_o
);

  logic                     fire;
  logic                     ready;
  logic [cen_pkg::CP_W-1:0] cp;
  logic                     eol;
  cen_pkg::pair_t           pair;

  cen_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .stall_o       (in_stall_o),
    .code_point_i  (code_point_i),
    .end_of_line_i (end_of_line_i),
    .take_i        (ready),
    .fire_o        (fire),
    .code_point_o  (cp),
    .end_of_line_o (eol)
  );

  cen_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .code_point_i  (cp),
    .end_of_line_i (eol),
    .pair_o        (pair)
  );

  cen_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .pair_i     (pair),
    .ready_o    (ready),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .char_out_o (char_out_o),
    .rejected_o (rejected_o),
    .last_o     (last_of_run_o)
  );

`ifndef NO_ASSERTIONS
  a_rejected_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> char_out_o == '0)
    else $error("rejected result carries a nonzero code point");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |=> out_valid_o)
    else $error("result run ended without a last marker");
`endif

endmodule
